// ===== hw/rtl/sia_pkg.sv =====
// Shared constants, codes and types of the stack integer ALU.
`default_nettype none

package sia_pkg;

	// Stack geometry
	localparam int STACK_DEPTH = 64;
	localparam int WORD_W      = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DEPTH_OUT_W = 7;
	localparam int ITER_W      = $clog2(WORD_W);

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// Command codes
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_PUSH = 2'd0;
	localparam cmd_t CMD_POP  = 2'd1;
	localparam cmd_t CMD_ALU  = 2'd2;

	// ALU opcodes
	typedef logic [7:0] opcode_t;
	localparam opcode_t OP_ADD = 8'h34;
	localparam opcode_t OP_SUB = 8'h35;
	localparam opcode_t OP_MUL = 8'h36;
	localparam opcode_t OP_DIV = 8'h37;
	localparam opcode_t OP_REM = 8'h38;
	localparam opcode_t OP_LAND = 8'h3a;
	localparam opcode_t OP_LOR = 8'h3b;
	localparam opcode_t OP_BAND = 8'h3c;
	localparam opcode_t OP_BOR = 8'h3d;
	localparam opcode_t OP_LT = 8'h3e;
	localparam opcode_t OP_GT = 8'h3f;
	localparam opcode_t OP_LE = 8'h40;
	localparam opcode_t OP_GE = 8'h41;
	localparam opcode_t OP_EQ = 8'h42;
	localparam opcode_t OP_NE = 8'h43;

	// Result status
	typedef enum logic [2:0] {
		STAT_OK     = 3'd0,
		STAT_UNDER  = 3'd1,
		STAT_OVER   = 3'd2,
		STAT_DIVZ   = 3'd3,
		STAT_DIVOVF = 3'd4,
		STAT_UNSUP  = 3'd5
	} status_t;

	// Sequencer of the top level
	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_RD,
		S_RD_LEFT,
		S_OPS,
		S_EXEC,
		S_MULDIV,
		S_WB,
		S_FIN
	} sia_state_t;

	// Iterative multiply/divide unit
	typedef enum logic [1:0] {
		MD_MUL,
		MD_DIV,
		MD_REM
	} md_op_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_RUN,
		MD_FIX
	} md_state_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
		word_t  lhs;
		word_t  rhs;
	} md_req_t;

	typedef struct packed {
		logic  done;
		word_t result;
	} md_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sia_if.sv =====
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface sia_req_if;
	import sia_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          command;
	logic [7:0]          alu_code;
	logic signed [WORD_W-1:0] push_value;

	modport source (output valid, output command, output alu_code, output push_value,
		input ready);
	modport sink (input valid, input command, input alu_code, input push_value,
		output ready);
endinterface

interface sia_rsp_if;
	import sia_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [2:0]               status;
	logic signed [WORD_W-1:0] result_value;
	logic [DEPTH_OUT_W-1:0]   stack_depth;

	modport source (output valid, output status, output result_value, output stack_depth,
		input ready);
	modport sink (input valid, input status, input result_value, input stack_depth,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sia_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sia_muldiv.sv =====
// Shared iterative unit: shift-add multiply and restoring signed divide/remainder.
`default_nettype none

module sia_muldiv import sia_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire md_req_t req,
	output md_rsp_t      rsp
);

	md_state_t         state_q, state_d;
	md_op_t            op_q;
	word_t             acc_q;   // product, or partial remainder
	word_t             a_q;     // multiplicand, or dividend shifting into quotient
	word_t             b_q;     // multiplier, or divisor magnitude
	logic              neg_q;   // sign fix for divide/remainder
	logic [ITER_W-1:0] iter_q;

	logic              is_div;
	logic [WORD_W:0]   add_x, add_y, add_sum;
	word_t             lhs_abs, rhs_abs;

	// one shared adder: accumulate for multiply, trial subtract for divide
	always_comb begin
		is_div  = (op_q != MD_MUL);
		add_x   = is_div ? {acc_q, a_q[WORD_W-1]} : {1'b0, acc_q};
		add_y   = is_div ? ~{1'b0, b_q} : {1'b0, a_q};
		add_sum = add_x + add_y + {{WORD_W{1'b0}}, is_div};
	end

	always_comb begin
		lhs_abs = req.lhs[WORD_W-1] ? (~req.lhs + 1'b1) : req.lhs;
		rhs_abs = req.rhs[WORD_W-1] ? (~req.rhs + 1'b1) : req.rhs;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MD_IDLE: if (req.start) state_d = MD_RUN;
			MD_RUN:  if (iter_q == '0) state_d = MD_FIX;
			MD_FIX:  state_d = MD_IDLE;
			default: state_d = MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == MD_IDLE && req.start) begin
			op_q   <= req.op;
			acc_q  <= '0;
			iter_q <= ITER_W'(WORD_W - 1);
			if (req.op == MD_MUL) begin
				a_q   <= req.lhs;
				b_q   <= req.rhs;
				neg_q <= 1'b0;
			end else begin
				a_q   <= lhs_abs;
				b_q   <= rhs_abs;
				neg_q <= (req.op == MD_DIV) ? (req.lhs[WORD_W-1] ^ req.rhs[WORD_W-1])
				                            : req.lhs[WORD_W-1];
			end
		end else if (state_q == MD_RUN) begin
			iter_q <= iter_q - 1'b1;
			if (is_div) begin
				// negative trial keeps the shifted remainder
				if (add_sum[WORD_W]) begin
					acc_q <= {acc_q[WORD_W-2:0], a_q[WORD_W-1]};
					a_q   <= {a_q[WORD_W-2:0], 1'b0};
				end else begin
					acc_q <= add_sum[WORD_W-1:0];
					a_q   <= {a_q[WORD_W-2:0], 1'b1};
				end
			end else begin
				if (b_q[0]) begin
					acc_q <= add_sum[WORD_W-1:0];
				end
				a_q <= {a_q[WORD_W-2:0], 1'b0};
				b_q <= {1'b0, b_q[WORD_W-1:1]};
			end
		end
	end

	// outputs: result with sign correction in the last cycle
	always_comb begin
		rsp.done = (state_q == MD_FIX);
		case (op_q)
			MD_DIV:  rsp.result = neg_q ? (~a_q + 1'b1) : a_q;
			MD_REM:  rsp.result = neg_q ? (~acc_q + 1'b1) : acc_q;
			default: rsp.result = acc_q;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/stack_integer_alu.sv =====
// Stack integer ALU: operand stack in RAM, sequencer and shared multiply/divide unit.
// Steps from request accept to result valid: push goes straight to the output stage, pop
// reads the top word, add/sub/logic/compare read both operands, execute and write back, and
// multiply/divide/remainder run 32 iterations of the shared unit plus sign fix in between.
// One request at a time: the next request is accepted the cycle after the output register loads.
// Reset clears the stack count, sequencer and output valid; stack words stay undefined.
`default_nettype none

module stack_integer_alu import sia_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	sia_req_if.sink  req,
	sia_rsp_if.source rsp
);

	sia_state_t           state_q, state_d;
	logic [CNT_W-1:0]     count_q;
	opcode_t              code_q;
	word_t                lhs_q, rhs_q;
	word_t                value_q;
	status_t              status_q;

	logic                 rsp_valid_q;
	status_t              rsp_status_q;
	word_t                rsp_value_q;
	logic [DEPTH_OUT_W-1:0] rsp_depth_q;

	logic                 acc;
	logic                 full, empty;
	logic [CNT_W-1:0]     count_dec;
	logic                 rsp_load;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
	word_t                ram_wdata, ram_rdata;

	md_req_t              md_req;
	md_rsp_t              md_rsp;

	word_t                exec_val;
	status_t              exec_stat;
	logic                 exec_simple, exec_md;
	md_op_t               exec_op;

	assign acc       = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign empty     = (count_q == '0);
	assign count_dec = count_q - 1'b1;
	assign rsp_load  = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);

	// stack storage
	sia_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sia_muldiv u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.rsp   (md_rsp)
	);

	// opcode decode and combinational operations
	always_comb begin
		exec_val    = '0;
		exec_stat   = STAT_OK;
		exec_simple = 1'b0;
		exec_md     = 1'b0;
		exec_op     = MD_MUL;
		unique case (code_q) inside
			OP_ADD: begin exec_val = lhs_q + rhs_q; exec_simple = 1'b1; end
			OP_SUB: begin exec_val = lhs_q - rhs_q; exec_simple = 1'b1; end
			OP_MUL: begin exec_md = 1'b1; exec_op = MD_MUL; end
			OP_DIV, OP_REM: begin
				exec_op = (code_q == OP_DIV) ? MD_DIV : MD_REM;
				if (rhs_q == '0) begin
					exec_stat = STAT_DIVZ;
				end else if (lhs_q == WORD_MIN && rhs_q == '1) begin
					exec_stat = STAT_DIVOVF;
				end else begin
					exec_md = 1'b1;
				end
			end
			OP_LAND: begin
				exec_val    = WORD_W'(lhs_q != '0 && rhs_q != '0);
				exec_simple = 1'b1;
			end
			OP_LOR: begin
				exec_val    = WORD_W'(lhs_q != '0 || rhs_q != '0);
				exec_simple = 1'b1;
			end
			OP_BAND: begin exec_val = lhs_q & rhs_q; exec_simple = 1'b1; end
			OP_BOR:  begin exec_val = lhs_q | rhs_q; exec_simple = 1'b1; end
			OP_LT: begin
				exec_val = WORD_W'($signed(lhs_q) < $signed(rhs_q)); exec_simple = 1'b1;
			end
			OP_GT: begin
				exec_val = WORD_W'($signed(lhs_q) > $signed(rhs_q)); exec_simple = 1'b1;
			end
			OP_LE: begin
				exec_val = WORD_W'($signed(lhs_q) <= $signed(rhs_q)); exec_simple = 1'b1;
			end
			OP_GE: begin
				exec_val = WORD_W'($signed(lhs_q) >= $signed(rhs_q)); exec_simple = 1'b1;
			end
			OP_EQ: begin exec_val = WORD_W'(lhs_q == rhs_q); exec_simple = 1'b1; end
			OP_NE: begin exec_val = WORD_W'(lhs_q != rhs_q); exec_simple = 1'b1; end
			default: exec_stat = STAT_UNSUP;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (req.command)
						CMD_PUSH: state_d = S_FIN;
						CMD_POP:  state_d = empty ? S_FIN : S_POP_RD;
						CMD_ALU:  state_d = (count_q < CNT_W'(2)) ? S_FIN : S_RD_LEFT;
						default:  state_d = S_FIN;
					endcase
				end
			end
			S_POP_RD:  state_d = S_FIN;
			S_RD_LEFT: state_d = S_OPS;
			S_OPS:     state_d = S_EXEC;
			S_EXEC: begin
				if (exec_simple) begin
					state_d = S_WB;
				end else if (exec_md) begin
					state_d = S_MULDIV;
				end else begin
					state_d = S_FIN;
				end
			end
			S_MULDIV: if (md_rsp.done) state_d = S_WB;
			S_WB:     state_d = S_FIN;
			S_FIN:    if (rsp_load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: RAM ports, unit start, request ready
	always_comb begin
		req.ready    = (state_q == S_IDLE);
		ram_we       = 1'b0;
		ram_waddr    = count_q[ADDR_W-1:0];
		ram_wdata    = req.push_value;
		ram_raddr    = count_dec[ADDR_W-1:0];
		md_req.start = (state_q == S_EXEC) && exec_md;
		md_req.op    = exec_op;
		md_req.lhs   = lhs_q;
		md_req.rhs   = rhs_q;
		unique case (state_q)
			S_IDLE:    ram_we = acc && (req.command == CMD_PUSH) && !full;
			S_RD_LEFT: ram_raddr = count_q[ADDR_W-1:0];
			S_WB: begin
				ram_we    = 1'b1;
				ram_wdata = value_q;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				unique case (req.command)
					CMD_PUSH: if (!full) count_q <= count_q + 1'b1;
					CMD_POP:  if (!empty) count_q <= count_dec;
					CMD_ALU:  count_q <= (count_q < CNT_W'(2)) ? '0 : count_q - CNT_W'(2);
					default:  count_q <= count_q;
				endcase
			end else if (state_q == S_WB) begin
				count_q <= count_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			code_q  <= req.alu_code;
			value_q <= '0;
			unique case (req.command)
				CMD_PUSH: status_q <= full ? STAT_OVER : STAT_OK;
				CMD_POP:  status_q <= empty ? STAT_UNDER : STAT_OK;
				CMD_ALU:  status_q <= (count_q < CNT_W'(2)) ? STAT_UNDER : STAT_OK;
				default:  status_q <= STAT_UNSUP;
			endcase
		end
		unique case (state_q)
			S_POP_RD:  value_q <= ram_rdata;
			S_RD_LEFT: rhs_q <= ram_rdata;
			S_OPS:     lhs_q <= ram_rdata;
			S_EXEC: begin
				status_q <= exec_stat;
				if (exec_simple) value_q <= exec_val;
			end
			S_MULDIV:  if (md_rsp.done) value_q <= md_rsp.result;
			default:   ;
		endcase
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_value_q  <= value_q;
			rsp_depth_q  <= DEPTH_OUT_W'(count_q);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.result_value = rsp_value_q;
	assign rsp.stack_depth  = rsp_depth_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !full)
		else $error("stack write while full");

	a_md_to_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MULDIV && md_rsp.done) |=> state_q == S_WB)
		else $error("multiply/divide result not written back");

	a_wb_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WB |=> count_q == $past(count_q) + 1'b1)
		else $error("write-back did not grow the stack");

	a_ready_no_md: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> state_q == S_MULDIV)
		else $error("unit finished outside of its wait state");
`endif

endmodule

`default_nettype wire
